// File: hdl/cms_pkg.sv
// shared types, constants and identifier packing for the can message segmenter
package cms_pkg;

  // frame size, queue depth, pointer and count widths, and own station reset value
  localparam int PACK_BYTES_DEF = 8;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);
  localparam logic [6:0] OWN_STATION_RST = 7'd1;

  // segment kind codes
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_FIRST  = 2'd1,
    KIND_MIDDLE = 2'd2,
    KIND_FINAL  = 2'd3
  } seg_kind_t;

  // one finished frame
  typedef struct packed {
    logic [28:0] ext_id;
    seg_kind_t   kind;
    logic [3:0]  len;
    logic [63:0] data;
    logic        done;
  } frame_t;

  // push request from the front to the queue
  typedef struct packed {
    logic slot0_en;
    logic slot1_en;
  } push_t;

  // extended identifier: dest, kind, segment, function, own station
  function automatic logic [28:0] make_id(input logic [6:0] own, input logic [4:0] func,
                                          input logic [7:0] seg, input seg_kind_t kind,
                                          input logic [6:0] dest);
    make_id = {dest, kind, seg, func, own};
  endfunction

endpackage

// File: hdl/cms_front.sv
// front end: collects message bytes and builds frames for the queue
module cms_front #(
  parameter int PACK_BYTES = cms_pkg::PACK_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      payload_byte,
  input  logic            last_byte,
  input  logic [4:0]      func_code,
  input  logic [6:0]      dest_station,
  input  logic            cfg_wr_en,
  input  logic [6:0]      cfg_wr_data,
  output cms_pkg::push_t  push,
  output cms_pkg::frame_t slot0,
  output cms_pkg::frame_t slot1
);

  localparam int IDX_W = (PACK_BYTES > 1) ? $clog2(PACK_BYTES) : 1;
  localparam int CNT_W = $clog2(PACK_BYTES + 1);

  logic [7:0]       byte_store [PACK_BYTES];
  logic [CNT_W-1:0] byte_count;
  logic             frames_emitted;
  logic [7:0]       seg_counter;
  logic [4:0]       held_func;
  logic [6:0]       held_dest;
  logic [6:0]       own_station;

  logic             start;
  logic             full;
  logic [4:0]       func_cur;
  logic [6:0]       dest_cur;
  logic [7:0]       seg_cur;
  logic [CNT_W-1:0] cnt1;
  logic             emitted1;
  logic [7:0]       seg1;
  logic [63:0]      data_a;
  logic [63:0]      data_b;
  logic [7:0]       seg_b;
  cms_pkg::seg_kind_t kind_a;
  cms_pkg::seg_kind_t kind_b;
  cms_pkg::frame_t  frame_a;
  cms_pkg::frame_t  frame_b;

  // classify the incoming item
  always_comb begin
    start    = (byte_count == '0) && !frames_emitted;
    full     = (byte_count == CNT_W'(PACK_BYTES));
    func_cur = start ? func_code : held_func;
    dest_cur = start ? dest_station : held_dest;
    seg_cur  = start ? 8'd0 : seg_counter;
    cnt1     = full ? '0 : byte_count;
    emitted1 = full || frames_emitted;
    seg1     = full ? seg_cur + 8'd1 : seg_cur;
    kind_a   = frames_emitted ? cms_pkg::KIND_MIDDLE : cms_pkg::KIND_FIRST;
    kind_b   = emitted1 ? cms_pkg::KIND_FINAL : cms_pkg::KIND_NONE;
    seg_b    = emitted1 ? seg1 : 8'd0;
  end

  // frame data for the held full frame and the closing frame
  always_comb begin
    data_a = '0;
    data_b = '0;
    for (int i = 0; i < PACK_BYTES; i++) begin
      data_a[8*i +: 8] = byte_store[i];
      if (CNT_W'(i) < cnt1) begin
        data_b[8*i +: 8] = byte_store[i];
      end else if (CNT_W'(i) == cnt1) begin
        data_b[8*i +: 8] = payload_byte;
      end
    end
  end

  // frame descriptors
  always_comb begin
    frame_a.ext_id = cms_pkg::make_id(own_station, func_cur, seg_cur, kind_a, dest_cur);
    frame_a.kind   = kind_a;
    frame_a.len    = 4'(PACK_BYTES);
    frame_a.data   = data_a;
    frame_a.done   = 1'b0;
    frame_b.ext_id = cms_pkg::make_id(own_station, func_cur, seg_b, kind_b, dest_cur);
    frame_b.kind   = kind_b;
    frame_b.len    = 4'(cnt1) + 4'd1;
    frame_b.data   = data_b;
    frame_b.done   = 1'b1;
  end

  // push slots, packed so the first enabled frame sits in slot 0
  always_comb begin
    push.slot0_en = accept && (full || last_byte);
    push.slot1_en = accept && full && last_byte;
    slot0         = full ? frame_a : frame_b;
    slot1         = frame_b;
  end

  // message state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      frames_emitted <= 1'b0;
      seg_counter    <= 8'd0;
      held_func      <= 5'd0;
      held_dest      <= 7'd0;
      own_station    <= cms_pkg::OWN_STATION_RST;
    end else begin
      if (cfg_wr_en) begin
        own_station <= cfg_wr_data;
      end
      if (accept) begin
        held_func <= func_cur;
        held_dest <= dest_cur;
        if (last_byte) begin
          byte_count     <= '0;
          frames_emitted <= 1'b0;
          seg_counter    <= 8'd0;
        end else begin
          byte_count     <= cnt1 + CNT_W'(1);
          frames_emitted <= emitted1;
          seg_counter    <= seg1;
        end
      end
    end
  end

  // byte storage
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_store[cnt1[IDX_W-1:0]] <= payload_byte;
    end
  end

endmodule

// File: hdl/cms_queue.sv
// frame queue with two push slots and one pop port
module cms_queue (
  input  logic            clk,
  input  logic            rst,
  input  cms_pkg::push_t  push,
  input  cms_pkg::frame_t slot0,
  input  cms_pkg::frame_t slot1,
  input  logic            pop,
  output cms_pkg::frame_t head,
  output logic            not_empty,
  output logic            room2
);

  cms_pkg::frame_t              entries [cms_pkg::QDEPTH];
  logic [cms_pkg::QPTR_W-1:0]   wr_ptr;
  logic [cms_pkg::QPTR_W-1:0]   rd_ptr;
  logic [cms_pkg::QCNT_W-1:0]   count;
  logic [cms_pkg::QCNT_W-1:0]   count_next;
  logic [cms_pkg::QPTR_W-1:0]   wr_ptr1;
  logic [cms_pkg::QCNT_W-1:0]   n_push;

  // status and head
  always_comb begin
    not_empty = (count != '0);
    room2     = (count <= cms_pkg::QCNT_W'(cms_pkg::QDEPTH - 2));
    head      = entries[rd_ptr];
    wr_ptr1   = wr_ptr + cms_pkg::QPTR_W'(1);
    n_push    = cms_pkg::QCNT_W'(push.slot0_en) + cms_pkg::QCNT_W'(push.slot1_en);
    count_next = count + n_push - cms_pkg::QCNT_W'(pop);
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[cms_pkg::QPTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + cms_pkg::QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.slot0_en) begin
      entries[wr_ptr] <= slot0;
    end
    if (push.slot1_en) begin
      entries[wr_ptr1] <= slot1;
    end
  end

`ifndef SYNTH
  // fill level stays within depth
  a_level: assert property (@(posedge clk) disable iff (rst)
    count <= cms_pkg::QCNT_W'(cms_pkg::QDEPTH))
    else $error("queue level exceeds depth");

  // never pushes more than there is room for
  a_room: assert property (@(posedge clk) disable iff (rst)
    (push.slot0_en || push.slot1_en) |-> room2)
    else $error("push without room");

  // second slot only with the first
  a_order: assert property (@(posedge clk) disable iff (rst)
    push.slot1_en |-> push.slot0_en)
    else $error("second slot pushed alone");

  // pop only from a filled queue
  a_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");
`endif

endmodule

// File: hdl/cms_back.sv
// back end: output register that hands frames to the bus side
module cms_back (
  input  logic            clk,
  input  logic            rst,
  input  cms_pkg::frame_t head,
  input  logic            not_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [28:0]     ext_identifier,
  output logic [1:0]      seg_kind,
  output logic [3:0]      frame_len,
  output logic [63:0]     frame_bytes,
  output logic            message_done
);

  cms_pkg::frame_t out_frame;

  // load a new frame when the register is empty or being taken
  assign pop = not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_frame <= head;
    end
  end

  // output fields
  assign ext_identifier = out_frame.ext_id;
  assign seg_kind       = out_frame.kind;
  assign frame_len      = out_frame.len;
  assign frame_bytes    = out_frame.data;
  assign message_done   = out_frame.done;

`ifndef SYNTH
  // a loaded frame is shown next cycle
  a_load: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("loaded frame not shown");

  // a waiting frame is not replaced
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !pop)
    else $error("frame replaced while waiting");

  // the identifier kind field matches the kind output
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ext_identifier[21:20] == seg_kind))
    else $error("identifier kind mismatch");
`endif

endmodule

// File: hdl/can_message_segmenter.sv
// top level of the can message segmenter
// throughput: one byte item per cycle while in_stall is low; frames leave at most one per cycle
// a closing frame passes through the frame queue and then the output register after its
//   last byte is taken, a full first or middle frame only after the byte that follows it
// the byte input stalls only when the four-entry frame queue has under two free slots
// reset (synchronous, rst high) empties the queue and output, clears message
//   state and sets own station to 1
module can_message_segmenter #(
  parameter int PACK_BYTES = cms_pkg::PACK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  payload_byte,
  input  logic        last_byte,
  input  logic [4:0]  func_code,
  input  logic [6:0]  dest_station,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [28:0] ext_identifier,
  output logic [1:0]  seg_kind,
  output logic [3:0]  frame_len,
  output logic [63:0] frame_bytes,
  output logic        message_done
);

  cms_pkg::push_t  push;
  cms_pkg::frame_t slot0;
  cms_pkg::frame_t slot1;
  cms_pkg::frame_t head;
  logic            not_empty;
  logic            room2;
  logic            pop;
  logic            accept;

  // input handshake
  assign in_stall = !room2;
  assign accept   = in_valid && !in_stall;

  cms_front #(
    .PACK_BYTES (PACK_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .func_code    (func_code),
    .dest_station (dest_station),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .push         (push),
    .slot0        (slot0),
    .slot1        (slot1)
  );

  cms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .slot0     (slot0),
    .slot1     (slot1),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  cms_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .not_empty      (not_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ext_identifier (ext_identifier),
    .seg_kind       (seg_kind),
    .frame_len      (frame_len),
    .frame_bytes    (frame_bytes),
    .message_done   (message_done)
  );

endmodule

// File: tb/frame_checker.sv
// frame checker: watches both channels of the segmenter, predicts frames and compares them
module frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  payload_byte,
  input  logic        last_byte,
  input  logic [4:0]  func_code,
  input  logic [6:0]  dest_station,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [28:0] ext_identifier,
  input  logic [1:0]  seg_kind,
  input  logic [3:0]  frame_len,
  input  logic [63:0] frame_bytes,
  input  logic        message_done,
  output int          fail_count,
  output int          frames_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES = cms_pkg::PACK_BYTES_DEF;

  // predicted segmenter state
  logic [6:0] station;
  logic [7:0] store [8];
  logic [3:0] count;
  logic       started;
  logic [7:0] seg_no;
  logic [4:0] msg_func;
  logic [6:0] msg_dest;

  cms_pkg::frame_t frames_due [$];
  cms_pkg::frame_t want;
  int     frame_no = 0;
  int     errors = 0;

  assign fail_count = errors;

  // build the frame for the bytes currently held
  function automatic cms_pkg::frame_t pack_frame(input cms_pkg::seg_kind_t kind,
                                                 input logic done);
    cms_pkg::frame_t f;
    logic [7:0]      seg;
    f.data = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < count) f.data[8*i +: 8] = store[i];
    end
    // an unsegmented frame carries segment number zero
    seg = (kind == cms_pkg::KIND_NONE) ? 8'd0 : seg_no;
    f.ext_id = {msg_dest, kind, seg, msg_func, station};
    f.kind = kind;
    f.len = count;
    f.done = done;
    return f;
  endfunction

  // one line per wrong field, and count it
  task automatic note_error(input string what, input logic [63:0] got, input logic [63:0] wanted);
    $display("%0t ns frame %0d: %s got 'h%0h wanted 'h%0h", $realtime, frame_no, what,
             got, wanted);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      station = cms_pkg::OWN_STATION_RST;
      count = '0;
      started = 1'b0;
      seg_no = '0;
      msg_func = '0;
      msg_dest = '0;
      for (int i = 0; i < 8; i++) store[i] = '0;
      frames_due.delete();
      frames_pending <= 0;
    end else begin
      // station register write
      if (cfg_wr_en) station = cfg_wr_data;

      // predict frames caused by an accepted byte item
      if (in_valid && !in_stall) begin
        // function and destination latch on the first byte only
        if (count == 0 && !started) begin
          msg_func = func_code;
          msg_dest = dest_station;
          seg_no = '0;
        end
        // a held full frame is released as first or middle
        if (count >= FRAME_BYTES) begin
          frames_due.push_back(pack_frame(started ? cms_pkg::KIND_MIDDLE
                                                  : cms_pkg::KIND_FIRST, 1'b0));
          seg_no = seg_no + 8'd1;
          started = 1'b1;
          count = '0;
        end
        store[count[2:0]] = payload_byte;
        count = count + 4'd1;
        // closing frame of the message
        if (last_byte) begin
          frames_due.push_back(pack_frame(started ? cms_pkg::KIND_FINAL
                                                  : cms_pkg::KIND_NONE, 1'b1));
          count = '0;
          started = 1'b0;
          seg_no = '0;
        end
      end

      // compare an accepted frame with the oldest expected one
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          note_error("frame with none expected, ext_identifier", 64'(ext_identifier), 64'd0);
        end else begin
          want = frames_due.pop_front();
          if (ext_identifier !== want.ext_id)
            note_error("ext_identifier", 64'(ext_identifier), 64'(want.ext_id));
          if (seg_kind !== want.kind)
            note_error("seg_kind", 64'(seg_kind), 64'(want.kind));
          if (frame_len !== want.len)
            note_error("frame_len", 64'(frame_len), 64'(want.len));
          if (frame_bytes !== want.data) note_error("frame_bytes", frame_bytes, want.data);
          if (message_done !== want.done)
            note_error("message_done", 64'(message_done), 64'(want.done));
        end
        frame_no++;
      end
      frames_pending <= frames_due.size();
    end
  end

endmodule

// File: tb/can_message_segmenter_tb.sv
// testbench top for the can message segmenter: stimulus, receiver stalls and verdict
module can_message_segmenter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 4;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_OFF     = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES  = 280;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  payload_byte = '0;
  logic        last_byte = 1'b0;
  logic [4:0]  func_code = '0;
  logic [6:0]  dest_station = '0;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [28:0] ext_identifier;
  logic [1:0]  seg_kind;
  logic [3:0]  frame_len;
  logic [63:0] frame_bytes;
  logic        message_done;

  int   fail_count;
  int   frames_pending;
  int   cycle_count = 0;
  int   phase = 0;
  logic quiet = 1'b0;

  always #(HALF_PERIOD) clk = ~clk;

  can_message_segmenter dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .payload_byte  (payload_byte),
    .last_byte     (last_byte),
    .func_code     (func_code),
    .dest_station  (dest_station),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ext_identifier(ext_identifier),
    .seg_kind      (seg_kind),
    .frame_len     (frame_len),
    .frame_bytes   (frame_bytes),
    .message_done  (message_done)
  );

  frame_checker check_frames (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .payload_byte  (payload_byte),
    .last_byte     (last_byte),
    .func_code     (func_code),
    .dest_station  (dest_station),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ext_identifier(ext_identifier),
    .seg_kind      (seg_kind),
    .frame_len     (frame_len),
    .frame_bytes   (frame_bytes),
    .message_done  (message_done),
    .fail_count    (fail_count),
    .frames_pending(frames_pending)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // offer one byte item, with an optional gap first, and hold it until taken
  task automatic push_byte(input logic [7:0] b, input logic last, input logic [4:0] fc,
                           input logic [6:0] ds);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    payload_byte <= b;
    last_byte <= last;
    func_code <= fc;
    dest_station <= ds;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // a message of random bytes; function and destination change on every byte
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(0, 255)), i == len - 1, 5'($urandom_range(0, 31)),
                7'($urandom_range(0, 127)));
    end
  endtask

  // stop offering and wait until every expected frame has come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random stall bursts, one long hold-off in phase three
  initial begin
    logic held_off;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 3 && !held_off) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus
  initial begin
    int total;
    int len;
    int r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // single-byte message with every field at its top value, station at reset value
    push_byte(8'hFF, 1'b1, 5'd31, 7'd127);
    // exactly one full frame: unsegmented, length eight, zero function and destination
    for (int i = 0; i < 8; i++) begin
      push_byte(i[0] ? 8'hFF : 8'h00, i == 7, (i == 0) ? 5'd0 : 5'($urandom_range(0, 31)),
                (i == 0) ? 7'd0 : 7'($urandom_range(0, 127)));
    end
    // two full frames: first then final of length eight
    for (int i = 0; i < 16; i++) begin
      push_byte(8'($urandom_range(0, 255)), i == 15,
                (i == 0) ? 5'd31 : 5'($urandom_range(0, 31)),
                (i == 0) ? 7'd0 : 7'($urandom_range(0, 127)));
    end

    // random phases, each with its own station setting
    for (int p = 1; p <= 6; p++) begin
      settle();
      phase <= p;
      quiet <= (p == 6);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= (p == 1) ? 7'd0 : (p == 2) ? 7'd127 : 7'($urandom_range(0, 127));
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      total = 0;
      while (total < PHASE_BYTES) begin
        r = $urandom_range(0, 9);
        if (r < 6) len = $urandom_range(1, 17);
        else if (r < 9) len = 8 * $urandom_range(1, 4) + $urandom_range(0, 1);
        else len = $urandom_range(18, 64);
        send_message(len);
        total += len;
      end
    end

    settle();
    if (fail_count == 0 && frames_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
